FILE: rtl/rmsp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rmsp_pkg
// Shared types, constants and the seed table for the RMSProp update unit.
// ----------------------------------------------------------------------------
package rmsp_pkg;

  typedef struct packed {
    logic               req_type;
    logic [11:0]        elem_index;
    logic signed [15:0] gradient;
  } rmsp_req_t;

  typedef struct packed {
    logic [11:0]        out_index;
    logic signed [15:0] increment;
    logic               saturated;
  } rmsp_rsp_t;

  typedef struct packed {
    logic [15:0] learning_rate;
    logic [15:0] decay;
    logic [31:0] init_accum;
    logic [31:0] epsilon;
  } rmsp_cfg_t;

  // item handed from the accumulator front to the scaling back end
  typedef struct packed {
    logic        init;
    logic [11:0] idx;
    logic        neg;
    logic [15:0] mag;
    logic [31:0] na;
  } rmsp_acc_t;

  localparam int QDepth = 8;
  localparam int QAw    = $clog2(QDepth);
  localparam int QCw    = $clog2(QDepth + 1);

  typedef struct packed {
    logic           empty;
    logic [QCw-1:0] count;
  } rmsp_qstat_t;

  typedef enum logic [1:0] {
    REG_LR    = 2'd0,
    REG_DECAY = 2'd1,
    REG_INIT  = 2'd2,
    REG_EPS   = 2'd3
  } rmsp_reg_e;

  localparam logic [15:0] LrReset    = 16'd66;
  localparam logic [15:0] DecayReset = 16'd58982;
  localparam logic [31:0] InitReset  = 32'd1677722;
  localparam logic [31:0] EpsReset   = 32'd1;

  localparam logic [31:0] ThreeQ30 = 32'hC000_0000;

  // 1/sqrt seed in Q0.16 for mantissa segments of [1,4)
  function automatic logic [15:0] rsqrt_seed(input logic [3:0] idx);
    logic [15:0] s;
    case (idx)
      4'd0:    s = 16'd61788;
      4'd1:    s = 16'd55889;
      4'd2:    s = 16'd51411;
      4'd3:    s = 16'd47861;
      4'd4:    s = 16'd44957;
      4'd5:    s = 16'd42525;
      4'd6:    s = 16'd40450;
      4'd7:    s = 16'd38651;
      4'd8:    s = 16'd37073;
      4'd9:    s = 16'd35673;
      4'd10:   s = 16'd34421;
      default: s = 16'd33292;
    endcase
    return s;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/rmsp_cfg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rmsp_cfg
// APB register bank: learning rate, decay, init value and epsilon.
// ----------------------------------------------------------------------------
module rmsp_cfg (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [3:0]          paddr,
  input  wire logic [31:0]         pwdata,
  output logic [31:0]              prdata,
  output logic                     pready,
  output rmsp_pkg::rmsp_cfg_t      cfg_o
);
  import rmsp_pkg::*;

  rmsp_cfg_t cfg_q;
  rmsp_reg_e sel;
  logic      wr_en;

  assign sel    = rmsp_reg_e'(paddr[3:2]);
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.learning_rate <= LrReset;
      cfg_q.decay         <= DecayReset;
      cfg_q.init_accum    <= InitReset;
      cfg_q.epsilon       <= EpsReset;
    end else if (wr_en) begin
      case (sel)
        REG_LR:    cfg_q.learning_rate <= pwdata[15:0];
        REG_DECAY: cfg_q.decay         <= pwdata[15:0];
        REG_INIT:  cfg_q.init_accum    <= pwdata;
        REG_EPS:   cfg_q.epsilon       <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (sel)
      REG_LR:    prdata = {16'd0, cfg_q.learning_rate};
      REG_DECAY: prdata = {16'd0, cfg_q.decay};
      REG_INIT:  prdata = cfg_q.init_accum;
      REG_EPS:   prdata = cfg_q.epsilon;
      default:   prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

FILE: rtl/rmsp_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rmsp_front
// Accepts items, holds the accumulator store and runs the three-stage
// accumulator update; pushes each item into the queue.
// ----------------------------------------------------------------------------
module rmsp_front #(
  parameter int NUM_ELEMENTS = 4096
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start,
  output logic                      busy,
  input  wire rmsp_pkg::rmsp_req_t  req_i,
  input  wire rmsp_pkg::rmsp_cfg_t  cfg_i,
  input  wire rmsp_pkg::rmsp_qstat_t qstat_i,
  output logic                      push_o,
  output rmsp_pkg::rmsp_acc_t       push_data_o
);
  import rmsp_pkg::*;

  localparam int AW = (NUM_ELEMENTS > 1) ? $clog2(NUM_ELEMENTS) : 1;

  typedef struct packed {
    logic        upd;
    logic [11:0] idx;
    logic        in_range;
    logic        neg;
    logic [15:0] mag;
  } fr_t;

  logic [31:0] mem [NUM_ELEMENTS];

  logic        accept, hazard, full;
  logic [31:0] idx_ext;
  logic        inside_in;
  fr_t         in_d;
  logic        v1_q, v2_q, v3_q;
  fr_t         f1_q, f2_q, f3_q;
  logic [31:0] rdata_q;
  logic [31:0] acc;
  logic [47:0] p1_d, p1_q, p1b_q;
  logic [31:0] g2_d, g2_q;
  logic [16:0] wdec;
  logic [48:0] p2_d, p2_q;
  logic [49:0] sum;
  logic [31:0] na;
  logic [AW-1:0] rd_addr, wr_addr;
  logic [31:0] wr_ext;
  logic [QCw+1:0] fill;

  assign idx_ext   = 32'(req_i.elem_index);
  assign inside_in = idx_ext < 32'(NUM_ELEMENTS);
  assign rd_addr   = idx_ext[AW-1:0];

  // same entry still in flight: wait until its write-back has landed
  assign hazard = (v1_q && f1_q.idx == req_i.elem_index) ||
                  (v2_q && f2_q.idx == req_i.elem_index) ||
                  (v3_q && f3_q.idx == req_i.elem_index);
  assign fill   = (QCw+2)'(qstat_i.count) + (QCw+2)'(v1_q) + (QCw+2)'(v2_q)
                  + (QCw+2)'(v3_q);
  assign full   = fill >= (QCw+2)'(QDepth);
  assign busy   = hazard | full;
  assign accept = start & ~busy;

  always_comb begin
    in_d.upd      = req_i.req_type;
    in_d.idx      = req_i.elem_index;
    in_d.in_range = inside_in;
    in_d.neg      = req_i.gradient[15];
    in_d.mag      = req_i.gradient[15] ? 16'(-req_i.gradient) : 16'(req_i.gradient);
  end

  assign acc  = f1_q.in_range ? rdata_q : 32'd0;
  assign p1_d = 48'(cfg_i.decay) * 48'(acc);
  assign g2_d = 32'(f1_q.mag) * 32'(f1_q.mag);
  assign wdec = 17'h1_0000 - 17'(cfg_i.decay);
  assign p2_d = 49'(wdec) * 49'(g2_q);

  assign sum = 50'(p1b_q) + 50'(p2_q) + 50'd32768;
  assign na  = (|sum[49:48]) ? 32'hFFFF_FFFF : sum[47:16];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= accept;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    f1_q  <= in_d;
    f2_q  <= f1_q;
    f3_q  <= f2_q;
    p1_q  <= p1_d;
    g2_q  <= g2_d;
    p1b_q <= p1_q;
    p2_q  <= p2_d;
  end

  // accumulator store: registered read at accept, write-back from stage three
  assign wr_ext  = 32'(f3_q.idx);
  assign wr_addr = wr_ext[AW-1:0];

  always_ff @(posedge clk_i) begin
    if (accept) begin
      rdata_q <= mem[rd_addr];
    end
    if (v3_q && f3_q.in_range) begin
      mem[wr_addr] <= f3_q.upd ? na : cfg_i.init_accum;
    end
  end

  assign push_o = v3_q;
  always_comb begin
    push_data_o.init = ~f3_q.upd;
    push_data_o.idx  = f3_q.idx;
    push_data_o.neg  = f3_q.neg;
    push_data_o.mag  = f3_q.mag;
    push_data_o.na   = na;
  end

endmodule
`default_nettype wire

FILE: rtl/rmsp_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rmsp_queue
// Short FIFO between the accumulator front and the scaling back end.
// ----------------------------------------------------------------------------
module rmsp_queue (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 push_i,
  input  wire rmsp_pkg::rmsp_acc_t  push_data_i,
  input  wire logic                 pop_i,
  output rmsp_pkg::rmsp_acc_t       pop_data_o,
  output rmsp_pkg::rmsp_qstat_t     qstat_o
);
  import rmsp_pkg::*;

  rmsp_acc_t      slot_q [QDepth];
  logic [QAw-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCw-1:0] count_q;
  logic           do_pop;

  assign do_pop        = pop_i & (count_q != '0);
  assign pop_data_o    = slot_q[rd_ptr_q];
  assign qstat_o.empty = (count_q == '0);
  assign qstat_o.count = count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (do_pop) rd_ptr_q <= rd_ptr_q + 1'b1;
      if (push_i && !do_pop)      count_q <= count_q + 1'b1;
      else if (!push_i && do_pop) count_q <= count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/rmsp_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rmsp_back
// Scaling back end: sum with epsilon, normalise, seed plus Newton steps for
// 1/sqrt, scale by rate and gradient, round and saturate.
// ----------------------------------------------------------------------------
module rmsp_back #(
  parameter int NEWTON_STEPS = 2
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire rmsp_pkg::rmsp_qstat_t qstat_i,
  input  wire rmsp_pkg::rmsp_acc_t  item_i,
  input  wire rmsp_pkg::rmsp_cfg_t  cfg_i,
  output logic                      pop_o,
  output logic                      done_o,
  output rmsp_pkg::rmsp_rsp_t       rsp_o
);
  import rmsp_pkg::*;

  localparam int NS = 3 + 3 * NEWTON_STEPS;

  typedef struct packed {
    logic        init;
    logic [11:0] idx;
    logic        neg;
    logic [15:0] mag;
    logic        sat;
    logic [3:0]  half;
    logic [31:0] mq;
    logic [31:0] y;
    logic [31:0] tmp;
  } bk_t;

  logic [NS+1:0] vld_q;
  bk_t           st_q [NS];
  bk_t           st_d [NS];
  bk_t           b0_d, b1_d, b2_d;
  bk_t           m0_q, m1_q;
  logic [31:0]   lg_q;
  logic [63:0]   mag_q;
  logic          done_q;
  rmsp_rsp_t     rsp_q;
  logic [32:0]   s33;
  logic [4:0]    msb;
  logic [4:0]    nshift;
  logic [3:0]    seg;
  logic [63:0]   mag_d;
  logic [5:0]    sh;
  logic [63:0]   rsum, q64;
  rmsp_rsp_t     rsp_d;
  logic [63:0]   nt_sq, nt_um, nt_yd;
  logic [31:0]   nt_dd;

  assign pop_o = ~qstat_i.empty;

  // epsilon sum, clipped, zero taken as one LSB
  always_comb begin
    s33          = 33'(item_i.na) + 33'(cfg_i.epsilon);
    b0_d         = '0;
    b0_d.init    = item_i.init;
    b0_d.idx     = item_i.idx;
    b0_d.neg     = item_i.neg;
    b0_d.mag     = item_i.mag;
    b0_d.sat     = s33[32];
    b0_d.mq      = s33[32] ? 32'hFFFF_FFFF : s33[31:0];
    if (b0_d.mq == '0) b0_d.mq = 32'd1;
  end

  // normalise to [1,4) times an even power of two
  always_comb begin
    msb = '0;
    for (int i = 1; i < 32; i++) begin
      if (st_q[0].mq[i]) msb = 5'(i);
    end
    b1_d      = st_q[0];
    b1_d.half = msb[4:1];
    nshift    = 5'd30 - {msb[4:1], 1'b0};
    b1_d.mq   = st_q[0].mq << nshift;
  end

  always_comb begin
    seg    = st_q[1].mq[31:28] - 4'd4;
    if (seg > 4'd11) seg = 4'd11;
    b2_d   = st_q[1];
    b2_d.y = {2'b00, rsqrt_seed(seg), 14'd0};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      done_q <= 1'b0;
    end else begin
      vld_q  <= {vld_q[NS:0], pop_o};
      done_q <= vld_q[NS+1];
    end
  end

  // each Newton step: y*y, then m*t, then y*(3-u)/2
  always_comb begin
    st_d[0] = b0_d;
    st_d[1] = b1_d;
    st_d[2] = b2_d;
    for (int j = 0; j < NEWTON_STEPS; j++) begin
      nt_sq = 64'(st_q[3*j+2].y) * 64'(st_q[3*j+2].y);
      nt_um = 64'(st_q[3*j+3].mq) * 64'(st_q[3*j+3].tmp);
      nt_dd = (st_q[3*j+4].tmp >= ThreeQ30) ? 32'd0 : ThreeQ30 - st_q[3*j+4].tmp;
      nt_yd = 64'(st_q[3*j+4].y) * 64'(nt_dd);
      st_d[3*j+3]     = st_q[3*j+2];
      st_d[3*j+3].tmp = nt_sq[61:30];
      st_d[3*j+4]     = st_q[3*j+3];
      st_d[3*j+4].tmp = nt_um[61:30];
      st_d[3*j+5]     = st_q[3*j+4];
      st_d[3*j+5].y   = nt_yd[62:31];
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < NS; k++) begin
      st_q[k] <= st_d[k];
    end
  end

  assign mag_d = 64'(lg_q) * 64'(m0_q.y);

  always_ff @(posedge clk_i) begin
    m0_q  <= st_q[NS-1];
    lg_q  <= 32'(cfg_i.learning_rate) * 32'(st_q[NS-1].mag);
    m1_q  <= m0_q;
    mag_q <= mag_d;
    rsp_q <= rsp_d;
  end

  // round half up on the magnitude, then clip and apply opposite sign; init items give zero
  always_comb begin
    sh             = 6'd34 + 6'(m1_q.half);
    rsum           = mag_q + (64'd1 << (sh - 6'd1));
    q64            = rsum >> sh;
    rsp_d.out_index = m1_q.idx;
    rsp_d.saturated = m1_q.sat;
    if (!m1_q.neg) begin
      if (q64 > 64'd32768) begin
        q64             = 64'd32768;
        rsp_d.saturated = 1'b1;
      end
      rsp_d.increment = 16'(-q64[15:0]);
    end else begin
      if (q64 > 64'd32767) begin
        q64             = 64'd32767;
        rsp_d.saturated = 1'b1;
      end
      rsp_d.increment = q64[15:0];
    end
    if (m1_q.init) begin
      rsp_d.increment = '0;
      rsp_d.saturated = 1'b0;
    end
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule
`default_nettype wire

FILE: rtl/rmsprop_update_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rmsprop_update_unit
// RMSProp optimizer step per element over an indexed accumulator store.
// ----------------------------------------------------------------------------
// One item is taken per cycle while busy is low. Each item gives one result
// on rsp_o, marked by done_o for a single cycle; results come out in order
// and cannot be held off. busy rises when the queue fill plus the items in
// the three front stages reaches QDepth, and for an item whose elem_index
// matches one in those stages, until its accumulator write-back has landed
// (read, two multiply stages, write). The accumulator store is not cleared
// at reset; an init item loads its entry with init_accum.
// ----------------------------------------------------------------------------
module rmsprop_update_unit #(
  parameter int NUM_ELEMENTS = 4096,
  parameter int NEWTON_STEPS = 2
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start,
  output logic                     busy,
  input  wire rmsp_pkg::rmsp_req_t req_i,
  output logic                     done_o,
  output rmsp_pkg::rmsp_rsp_t      rsp_o,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [3:0]          paddr,
  input  wire logic [31:0]         pwdata,
  output logic [31:0]              prdata,
  output logic                     pready
);
  import rmsp_pkg::*;

  rmsp_cfg_t   cfg;
  rmsp_qstat_t qstat;
  rmsp_acc_t   push_data, pop_data;
  logic        push, pop;

  rmsp_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  rmsp_front #(
    .NUM_ELEMENTS (NUM_ELEMENTS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .req_i       (req_i),
    .cfg_i       (cfg),
    .qstat_i     (qstat),
    .push_o      (push),
    .push_data_o (push_data)
  );

  rmsp_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .qstat_o     (qstat)
  );

  rmsp_back #(
    .NEWTON_STEPS (NEWTON_STEPS)
  ) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .qstat_i (qstat),
    .item_i  (pop_data),
    .cfg_i   (cfg),
    .pop_o   (pop),
    .done_o  (done_o),
    .rsp_o   (rsp_o)
  );

endmodule
`default_nettype wire
